[design/stshelf_pkg.sv]
// ----------------------------------------------------------------------------
// stshelf_pkg
// Shared types, constants and arithmetic helpers for the stereo two-band
// shelving equalizer.
// ----------------------------------------------------------------------------
`default_nettype none

package stshelf_pkg;

    // Sample and coefficient formats.
    localparam int SAMPLE_BITS    = 24;
    localparam int COEF_BITS      = 24;
    localparam int COEF_FRAC_BITS = 20;
    localparam int PROD_BITS      = SAMPLE_BITS + COEF_BITS;
    // Three products summed need two extra bits of headroom.
    localparam int ACC_BITS       = PROD_BITS + 2;

    // Configuration port.
    localparam int CFG_IDX_BITS  = 3;
    localparam int CFG_DATA_BITS = COEF_BITS;

    // Reset values of the configuration registers (unity gain, bypass on).
    localparam logic signed [COEF_BITS-1:0] COEF_ONE =
        COEF_BITS'(1) <<< COEF_FRAC_BITS;

    // Register indexes.
    typedef enum logic [CFG_IDX_BITS-1:0] {
        REG_LOW_B0    = 3'd0,
        REG_LOW_B1    = 3'd1,
        REG_LOW_A1    = 3'd2,
        REG_HIGH_B0   = 3'd3,
        REG_HIGH_B1   = 3'd4,
        REG_HIGH_A1   = 3'd5,
        REG_EQ_BYPASS = 3'd6
    } t_reg_idx;

    // Sequencer states: multiply, then sum, for each band in turn.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOW_MUL,
        ST_LOW_SUM,
        ST_HIGH_MUL,
        ST_HIGH_SUM
    } t_state;

    // Request payloads.
    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] left_in;
        logic signed [SAMPLE_BITS-1:0] right_in;
    } t_in_req;

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] left_out;
        logic signed [SAMPLE_BITS-1:0] right_out;
    } t_out_req;

    // One band's coefficient set.
    typedef struct packed {
        logic signed [COEF_BITS-1:0] b0;
        logic signed [COEF_BITS-1:0] b1;
        logic signed [COEF_BITS-1:0] a1;
    } t_coef;

    // Sequencer controls shared by both lanes.
    typedef struct packed {
        logic load;       // capture a new input sample
        logic mul;        // register the three products
        logic band_high;  // operands come from the high shelf
        logic commit;     // the section result is final: update history
        logic bypass;     // pass the sample through, hold history
    } t_lane_ctl;

    localparam logic signed [ACC_BITS-1:0] ROUND_ADD =
        ACC_BITS'(1) <<< (COEF_FRAC_BITS - 1);
    localparam logic signed [ACC_BITS-1:0] SAT_HI =
        {{(ACC_BITS - SAMPLE_BITS + 1){1'b0}}, {(SAMPLE_BITS - 1){1'b1}}};
    localparam logic signed [ACC_BITS-1:0] SAT_LO = ~SAT_HI;

    // Round half up to sample precision, then saturate to the sample range.
    function automatic logic signed [SAMPLE_BITS-1:0] round_sat(
        input logic signed [ACC_BITS-1:0] acc
    );
        logic signed [ACC_BITS-1:0] shifted;
        shifted = (acc + ROUND_ADD) >>> COEF_FRAC_BITS;
        if (shifted > SAT_HI) begin
            return SAT_HI[SAMPLE_BITS-1:0];
        end else if (shifted < SAT_LO) begin
            return SAT_LO[SAMPLE_BITS-1:0];
        end
        return shifted[SAMPLE_BITS-1:0];
    endfunction

endpackage

`default_nettype wire

[design/stshelf_lane.sv]
// ----------------------------------------------------------------------------
// stshelf_lane
// One channel of the equalizer: a three-multiplier section unit shared by
// the low shelf and the high shelf, with the history of both sections.
// ----------------------------------------------------------------------------
`default_nettype none

module stshelf_lane (
    input  wire                                          i_clk,
    input  wire                                          i_rst_n,
    input  wire stshelf_pkg::t_lane_ctl                  i_ctl,
    input  wire logic signed [stshelf_pkg::SAMPLE_BITS-1:0] i_sample,
    input  wire stshelf_pkg::t_coef                      i_coef_low,
    input  wire stshelf_pkg::t_coef                      i_coef_high,
    output logic signed [stshelf_pkg::SAMPLE_BITS-1:0]   o_sample
);
    import stshelf_pkg::*;

    logic signed [SAMPLE_BITS-1:0] r_x;
    logic signed [SAMPLE_BITS-1:0] r_mid;
    logic signed [SAMPLE_BITS-1:0] r_xp_low;
    logic signed [SAMPLE_BITS-1:0] r_yp_low;
    logic signed [SAMPLE_BITS-1:0] r_xp_high;
    logic signed [SAMPLE_BITS-1:0] r_yp_high;
    logic signed [PROD_BITS-1:0]   r_p0;
    logic signed [PROD_BITS-1:0]   r_p1;
    logic signed [PROD_BITS-1:0]   r_p2;

    t_coef                         coef_sel;
    logic signed [SAMPLE_BITS-1:0] x_op;
    logic signed [SAMPLE_BITS-1:0] xp_op;
    logic signed [SAMPLE_BITS-1:0] yp_op;
    logic signed [ACC_BITS-1:0]    acc;
    logic signed [SAMPLE_BITS-1:0] y_sec;

    // Operand selection for the band being worked on.
    always_comb begin
        coef_sel = i_ctl.band_high ? i_coef_high : i_coef_low;
        x_op     = i_ctl.band_high ? r_mid       : r_x;
        xp_op    = i_ctl.band_high ? r_xp_high   : r_xp_low;
        yp_op    = i_ctl.band_high ? r_yp_high   : r_yp_low;
    end

    // Input capture.
    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_x <= i_sample;
        end
    end

    // Three multipliers, registered before the sum.
    always_ff @(posedge i_clk) begin
        if (i_ctl.mul) begin
            r_p0 <= coef_sel.b0 * x_op;
            r_p1 <= coef_sel.b1 * xp_op;
            r_p2 <= coef_sel.a1 * yp_op;
        end
    end

    // Sum of the products, rounded and saturated to a sample.
    always_comb begin
        acc   = ACC_BITS'(r_p0) + ACC_BITS'(r_p1) + ACC_BITS'(r_p2);
        y_sec = round_sat(acc);
    end

    // The low shelf result feeds the high shelf.
    always_ff @(posedge i_clk) begin
        if (i_ctl.commit && !i_ctl.band_high) begin
            r_mid <= y_sec;
        end
    end

    // Section history; bypass leaves it untouched.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_xp_low  <= '0;
            r_yp_low  <= '0;
            r_xp_high <= '0;
            r_yp_high <= '0;
        end else if (i_ctl.commit && !i_ctl.bypass) begin
            if (i_ctl.band_high) begin
                r_xp_high <= r_mid;
                r_yp_high <= y_sec;
            end else begin
                r_xp_low <= r_x;
                r_yp_low <= y_sec;
            end
        end
    end

    assign o_sample = i_ctl.bypass ? r_x : y_sec;

endmodule

`default_nettype wire

[design/stereo_two_band_shelf_equalizer.sv]
// ----------------------------------------------------------------------------
// stereo_two_band_shelf_equalizer
// Low shelf then high shelf, first-order IIR, on each of two stereo channels.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (i_in_valid / o_in_ready / i_in_data) takes one stereo
//   sample pair per request. Output channel (o_out_valid / i_out_ready /
//   o_out_data) returns one equalized pair per request, in order.
//   Two lanes, one per channel, run side by side; each lane has three
//   multipliers that serve the low shelf and then the high shelf.
//   Sequence: a taken request passes low multiply, low sum, high multiply
//   and high sum, then its result is registered; one request is in work at
//   a time, the next taken in the cycle the previous result is stored.
//   The output register holds a finished result while the next request is
//   in work. If the receiver stalls with a result still held, the finished
//   sum waits in its last step and no new request is taken.
//   Configuration: write i_cfg_wr_en / i_cfg_idx / i_cfg_data while idle;
//   indexes above the bypass register are ignored.
//   Reset (synchronous, active low): b0 of both shelves at unity, other
//   coefficients zero, bypass on, all section history zero, output empty.
// ----------------------------------------------------------------------------
`default_nettype none

module stereo_two_band_shelf_equalizer (
    input  wire                                       i_clk,
    input  wire                                       i_rst_n,
    input  wire                                       i_cfg_wr_en,
    input  wire  [stshelf_pkg::CFG_IDX_BITS-1:0]      i_cfg_idx,
    input  wire  [stshelf_pkg::CFG_DATA_BITS-1:0]     i_cfg_data,
    input  wire                                       i_in_valid,
    output logic                                      o_in_ready,
    input  wire stshelf_pkg::t_in_req                 i_in_data,
    output logic                                      o_out_valid,
    input  wire                                       i_out_ready,
    output stshelf_pkg::t_out_req                     o_out_data
);
    import stshelf_pkg::*;

    t_coef    r_coef_low;
    t_coef    r_coef_high;
    logic     r_eq_bypass;
    logic     r_bypass;
    t_state   r_state;
    t_state   n_state;
    logic     r_out_valid;
    t_out_req r_out_data;

    logic      in_acc;
    logic      out_free;
    logic      store;
    t_lane_ctl ctl;
    logic signed [SAMPLE_BITS-1:0] left_y;
    logic signed [SAMPLE_BITS-1:0] right_y;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_coef_low  <= '{b0: COEF_ONE, b1: '0, a1: '0};
            r_coef_high <= '{b0: COEF_ONE, b1: '0, a1: '0};
            r_eq_bypass <= 1'b1;
        end else if (i_cfg_wr_en) begin
            unique case (t_reg_idx'(i_cfg_idx))
                REG_LOW_B0:    r_coef_low.b0  <= i_cfg_data;
                REG_LOW_B1:    r_coef_low.b1  <= i_cfg_data;
                REG_LOW_A1:    r_coef_low.a1  <= i_cfg_data;
                REG_HIGH_B0:   r_coef_high.b0 <= i_cfg_data;
                REG_HIGH_B1:   r_coef_high.b1 <= i_cfg_data;
                REG_HIGH_A1:   r_coef_high.a1 <= i_cfg_data;
                REG_EQ_BYPASS: r_eq_bypass    <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // Handshake terms.
    assign out_free   = !r_out_valid || i_out_ready;
    assign store      = (r_state == ST_HIGH_SUM) && out_free;
    assign o_in_ready = (r_state == ST_IDLE) || store;
    assign in_acc     = i_in_valid && o_in_ready;

    // Sequencer state register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state and lane controls.
    always_comb begin
        n_state       = r_state;
        ctl.load      = in_acc;
        ctl.mul       = 1'b0;
        ctl.band_high = 1'b0;
        ctl.commit    = 1'b0;
        ctl.bypass    = r_bypass;
        unique case (r_state)
            ST_IDLE: begin
                if (in_acc) begin
                    n_state = ST_LOW_MUL;
                end
            end
            ST_LOW_MUL: begin
                ctl.mul = 1'b1;
                n_state = ST_LOW_SUM;
            end
            ST_LOW_SUM: begin
                ctl.commit = 1'b1;
                n_state    = ST_HIGH_MUL;
            end
            ST_HIGH_MUL: begin
                ctl.mul       = 1'b1;
                ctl.band_high = 1'b1;
                n_state       = ST_HIGH_SUM;
            end
            ST_HIGH_SUM: begin
                ctl.band_high = 1'b1;
                ctl.commit    = store;
                if (store) begin
                    n_state = in_acc ? ST_LOW_MUL : ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // Bypass is taken per request.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bypass <= 1'b1;
        end else if (in_acc) begin
            r_bypass <= r_eq_bypass;
        end
    end

    // Left and right lanes.
    stshelf_lane u_lane_left (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctl       (ctl),
        .i_sample    (i_in_data.left_in),
        .i_coef_low  (r_coef_low),
        .i_coef_high (r_coef_high),
        .o_sample    (left_y)
    );

    stshelf_lane u_lane_right (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctl       (ctl),
        .i_sample    (i_in_data.right_in),
        .i_coef_low  (r_coef_low),
        .i_coef_high (r_coef_high),
        .o_sample    (right_y)
    );

    // Merge both lanes into the output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (store) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (store) begin
            r_out_data.left_out  <= left_y;
            r_out_data.right_out <= right_y;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    // An accepted request always starts with the low shelf multiply.
    a_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> (r_state == ST_LOW_MUL))
        else $error("request accepted without starting the low shelf");

    // A new result appears only out of the high shelf sum.
    a_result_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_state == ST_HIGH_SUM))
        else $error("output valid raised outside the final sum step");

    // A held result is never overwritten by the next one.
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !i_out_ready) |-> !store)
        else $error("stored result overwritten while stalled");

endmodule

`default_nettype wire
